FILE: sv/lcdmw_pkg.sv
// Shared types and constants of the LCD memory-write pixel engine.
// No dependencies; compiled first.
package lcdmw_pkg;

	// Frame store size
	localparam int unsigned STORE_ROWS = 320;
	localparam int unsigned STORE_COLS = 240;

	localparam int unsigned ADDR_W  = 9;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned HELD_W  = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 9;

	// Input item function codes
	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_CONT  = 2'd1,
		FUNC_OTHER = 2'd2,
		FUNC_DATA  = 2'd3
	} func_t;

	// Pixel format codes; anything else is 18 bpp
	localparam logic [2:0] FMT_12BPP = 3'd3;
	localparam logic [2:0] FMT_16BPP = 3'd5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_START      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_END        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_START      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_END        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_XY      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COL_REVERSE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_REVERSE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd7;

	typedef struct packed {
		logic [ADDR_W-1:0] x_start;
		logic [ADDR_W-1:0] x_end;
		logic [ADDR_W-1:0] y_start;
		logic [ADDR_W-1:0] y_end;
		logic              swap_xy;
		logic              col_reverse;
		logic              row_reverse;
		logic [2:0]        pixel_format;
	} cfg_t;

	// Control from the pixel assembler to the address walker
	typedef struct packed {
		logic load;    // write-start command transfer
		logic advance; // pixel finished
	} addr_ctl_t;

	// Status from the address walker
	typedef struct packed {
		logic              in_store;
		logic [ADDR_W-1:0] row;
		logic [ADDR_W-1:0] col;
	} addr_stat_t;

endpackage

FILE: sv/lcdmw_if.sv
// Valid/ready channel interfaces for the byte stream and the pixel stream.
// Depends on lcdmw_pkg.
interface lcdmw_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic [lcdmw_pkg::CHAN_W-1:0] data_byte;

	modport source(output valid, output func, output data_byte, input ready);
	modport sink(input valid, input func, input data_byte, output ready);
endinterface

interface lcdmw_out_if;
	logic                         valid;
	logic                         ready;
	logic [lcdmw_pkg::ADDR_W-1:0] row;
	logic [lcdmw_pkg::CHAN_W-1:0] col;
	logic [lcdmw_pkg::CHAN_W-1:0] red;
	logic [lcdmw_pkg::CHAN_W-1:0] green;
	logic [lcdmw_pkg::CHAN_W-1:0] blue;

	modport source(output valid, output row, output col, output red, output green,
		output blue, input ready);
	modport sink(input valid, input row, input col, input red, input green,
		input blue, output ready);
endinterface

FILE: sv/lcdmw_cfg_regs.sv
// Configuration register file: window, orientation and pixel format.
// Depends on lcdmw_pkg.
module lcdmw_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [lcdmw_pkg::CFG_IDX_W-1:0]   index,
	input  logic [lcdmw_pkg::CFG_DATA_W-1:0]  wdata,
	output lcdmw_pkg::cfg_t                   cfg
);
	import lcdmw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_start      <= 9'd0;
			cfg_q.x_end        <= 9'd239;
			cfg_q.y_start      <= 9'd0;
			cfg_q.y_end        <= 9'd319;
			cfg_q.swap_xy      <= 1'b0;
			cfg_q.col_reverse  <= 1'b1;
			cfg_q.row_reverse  <= 1'b0;
			cfg_q.pixel_format <= 3'd6;
		end else if (we) begin
			case (index)
				REG_X_START:      cfg_q.x_start      <= wdata;
				REG_X_END:        cfg_q.x_end        <= wdata;
				REG_Y_START:      cfg_q.y_start      <= wdata;
				REG_Y_END:        cfg_q.y_end        <= wdata;
				REG_SWAP_XY:      cfg_q.swap_xy      <= wdata[0];
				REG_COL_REVERSE:  cfg_q.col_reverse  <= wdata[0];
				REG_ROW_REVERSE:  cfg_q.row_reverse  <= wdata[0];
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= wdata[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/lcdmw_assembler.sv
// Pixel assembler: pixel mode, byte phase and held channel fields; widens
// finished pixels to 8 bits per channel. Depends on lcdmw_pkg.
module lcdmw_assembler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [1:0]                     func,
	input  logic [lcdmw_pkg::CHAN_W-1:0]   data_byte,
	input  lcdmw_pkg::cfg_t                cfg,
	output lcdmw_pkg::addr_ctl_t           ctl,
	output logic [lcdmw_pkg::CHAN_W-1:0]   red,
	output logic [lcdmw_pkg::CHAN_W-1:0]   green,
	output logic [lcdmw_pkg::CHAN_W-1:0]   blue
);
	import lcdmw_pkg::*;

	logic              writing_q, writing_n;
	logic [1:0]        phase_q, phase_n;
	logic [HELD_W-1:0] first_q, second_q, third_q;
	logic [HELD_W-1:0] first_n, second_n, third_n;
	logic              done;
	logic [HELD_W-1:0] second_16;

	function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] c);
		return {c, c[5:4]};
	endfunction

	assign second_16 = second_q | {3'b000, data_byte[7:5]};

	always_comb begin
		writing_n = writing_q;
		phase_n   = phase_q;
		first_n   = first_q;
		second_n  = second_q;
		third_n   = third_q;
		done      = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		case (func_t'(func))
			FUNC_START, FUNC_CONT: begin
				writing_n = 1'b1;
				phase_n   = 2'd0;
			end
			FUNC_OTHER: begin
				writing_n = 1'b0;
				phase_n   = 2'd0;
			end
			default: begin
				if (writing_q) begin
					phase_n = phase_q + 2'd1;
					case (cfg.pixel_format)
						FMT_16BPP: begin
							if (phase_q == 2'd0) begin
								first_n  = {1'b0, data_byte[7:3]};
								second_n = {data_byte[2:0], 3'b000};
							end else if (phase_q == 2'd1) begin
								second_n = second_16;
								third_n  = {1'b0, data_byte[4:0]};
								phase_n  = 2'd0;
								done     = 1'b1;
								red      = widen5(data_byte[4:0]);
								green    = widen6(second_16);
								blue     = widen5(first_q[4:0]);
							end
						end
						FMT_12BPP: begin
							if (phase_q == 2'd0) begin
								first_n  = {2'b00, data_byte[7:4]};
								second_n = {2'b00, data_byte[3:0]};
							end else if (phase_q == 2'd1) begin
								third_n = {2'b00, data_byte[7:4]};
								first_n = {2'b00, data_byte[3:0]};
								done    = 1'b1;
								red     = widen5({data_byte[7:4], 1'b0});
								green   = widen6({second_q[3:0], 2'b00});
								blue    = widen5({first_q[3:0], 1'b0});
							end else if (phase_q == 2'd2) begin
								second_n = {2'b00, data_byte[7:4]};
								third_n  = {2'b00, data_byte[3:0]};
								phase_n  = 2'd0;
								done     = 1'b1;
								red      = widen5({data_byte[3:0], 1'b0});
								green    = widen6({data_byte[7:4], 2'b00});
								blue     = widen5({first_q[3:0], 1'b0});
							end
						end
						default: begin
							if (phase_q == 2'd0) begin
								first_n = data_byte[7:2];
							end else if (phase_q == 2'd1) begin
								second_n = data_byte[7:2];
							end else if (phase_q == 2'd2) begin
								third_n = data_byte[7:2];
								phase_n = 2'd0;
								done    = 1'b1;
								red     = widen6(data_byte[7:2]);
								green   = widen6(second_q);
								blue    = widen6(first_q);
							end
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			writing_q <= 1'b0;
			phase_q   <= 2'd0;
			first_q   <= '0;
			second_q  <= '0;
			third_q   <= '0;
		end else if (step) begin
			writing_q <= writing_n;
			phase_q   <= phase_n;
			first_q   <= first_n;
			second_q  <= second_n;
			third_q   <= third_n;
		end
	end

	assign ctl.load    = step && (func_t'(func) == FUNC_START);
	assign ctl.advance = step && done;

endmodule

FILE: sv/lcdmw_addr_walk.sv
// Address walker: row/column address registers stepping through the window,
// with reversal, wrap and exhaustion. Depends on lcdmw_pkg.
module lcdmw_addr_walk (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdmw_pkg::cfg_t        cfg,
	input  lcdmw_pkg::addr_ctl_t   ctl,
	output lcdmw_pkg::addr_stat_t  stat
);
	import lcdmw_pkg::*;

	logic [ADDR_W-1:0] row_q, col_q, row_n, col_n;
	logic              exh_q, exh_n;
	logic [ADDR_W-1:0] row_step;
	logic [7:0]        col_step;
	logic              win_ok;

	assign row_step = cfg.row_reverse ? row_q - 9'd1 : row_q + 9'd1;
	assign col_step = cfg.col_reverse ? col_q[7:0] - 8'd1 : col_q[7:0] + 8'd1;
	assign win_ok   = cfg.y_start <= cfg.y_end;

	always_comb begin
		row_n = row_q;
		col_n = col_q;
		exh_n = exh_q;
		if (ctl.load) begin
			row_n = cfg.swap_xy ? cfg.x_start : cfg.y_start;
			col_n = cfg.swap_xy ? cfg.y_start : cfg.x_start;
			exh_n = 1'b0;
		end else if (ctl.advance && !exh_q) begin
			if (cfg.swap_xy) begin
				// rows walk first
				if (row_q == cfg.x_end) begin
					if (col_q == cfg.y_end && win_ok) begin
						exh_n = 1'b1;
					end else begin
						row_n = cfg.x_start;
						col_n = {1'b0, col_step};
					end
				end else begin
					row_n = row_step;
				end
			end else begin
				if (col_q == cfg.x_end) begin
					if (row_q == cfg.y_end && win_ok) begin
						exh_n = 1'b1;
					end else begin
						col_n = cfg.x_start;
						row_n = row_step;
					end
				end else if (!col_q[8]) begin
					// column at 256 or above sticks until reloaded
					col_n = {1'b0, col_step};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			exh_q <= 1'b0;
		end else begin
			row_q <= row_n;
			col_q <= col_n;
			exh_q <= exh_n;
		end
	end

	assign stat.in_store = !exh_q && ({1'b0, row_q} < 10'(STORE_ROWS))
		&& ({1'b0, col_q} < 10'(STORE_COLS));
	assign stat.row = row_q;
	assign stat.col = col_q;

endmodule

FILE: sv/lcd_memory_write_pixel_engine_top.sv
// Top level of the LCD memory-write pixel engine: input register, assembler,
// address walker and result register. Depends on lcdmw_pkg, lcdmw_if and submodules.
//
// Takes one command or data byte per cycle and turns the memory-write stream
// into addressed 8-bit-per-channel pixels. Each transfer on pix_in is held in
// an input register and processed, once the result register is free or being
// read, by a single pass of shallow logic; a finished pixel inside the 320x240
// store lands in the result register and from there appears on pix_out.
// Throughput is one byte per cycle while pix_out is ready; the result register
// is the only point of back-pressure. Configuration writes take effect for the
// next byte and are meant to be issued while idle.
module lcd_memory_write_pixel_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	lcdmw_in_if.sink                          pix_in,
	lcdmw_out_if.source                       pix_out,
	input  logic                              cfg_we,
	input  logic [lcdmw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcdmw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lcdmw_pkg::*;

	cfg_t       cfg;
	addr_ctl_t  ctl;
	addr_stat_t stat;

	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [CHAN_W-1:0] byte_s1;
	logic              step;
	logic [CHAN_W-1:0] red, green, blue;

	logic              out_valid_q;
	logic [ADDR_W-1:0] row_q;
	logic [CHAN_W-1:0] col_q, red_q, green_q, blue_q;

	assign step         = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.valid && pix_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && pix_in.ready) begin
			func_s1 <= pix_in.func;
			byte_s1 <= pix_in.data_byte;
		end
	end

	lcdmw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	lcdmw_assembler u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.func      (func_s1),
		.data_byte (byte_s1),
		.cfg       (cfg),
		.ctl       (ctl),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	lcdmw_addr_walk u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctl    (ctl),
		.stat   (stat)
	);

	// result register; address is sampled before the walker steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.advance && stat.in_store) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && stat.in_store) begin
			row_q   <= stat.row;
			col_q   <= stat.col[7:0];
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.row   = row_q;
	assign pix_out.col   = col_q;
	assign pix_out.red   = red_q;
	assign pix_out.green = green_q;
	assign pix_out.blue  = blue_q;

endmodule

FILE: tb/lcdmw_pixel_checker.sv
// Passive checker for the LCD memory-write pixel engine: follows the config port and the
// byte stream, predicts the addressed pixels and compares them with every pix_out transfer.
// Depends on lcdmw_pkg and lcdmw_if.
module lcdmw_pixel_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	lcdmw_in_if                              byte_ch,
	lcdmw_out_if                             pix_ch,
	input  logic                             cfg_we,
	input  logic [lcdmw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcdmw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                      fails,
	output int unsigned                      pending,
	output int unsigned                      pixels_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import lcdmw_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] row;
		logic [CHAN_W-1:0] col;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	localparam cfg_t CFG_AT_RESET = '{x_start: 9'd0, x_end: 9'd239, y_start: 9'd0,
		y_end: 9'd319, swap_xy: 1'b0, col_reverse: 1'b1, row_reverse: 1'b0,
		pixel_format: 3'd6};

	cfg_t              regs;
	logic              writing;
	logic              exhausted;
	logic [1:0]        byte_phase;
	logic [HELD_W-1:0] held_first, held_second, held_third;
	logic [ADDR_W-1:0] row_addr, col_addr;
	pixel_t            expected_pixels[$];
	int unsigned       fail_total;
	int unsigned       checked_total;

	function automatic logic [7:0] widen5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] c);
		return {c, c[5:4]};
	endfunction

	task automatic walk_window();
		if (exhausted)
			return;
		if (regs.swap_xy) begin
			if (row_addr == regs.x_end) begin
				if (col_addr == regs.y_end && regs.y_start <= regs.y_end) begin
					exhausted = 1'b1;
				end else begin
					row_addr = regs.x_start;
					col_addr = {1'b0, regs.col_reverse ? col_addr[7:0] - 8'd1 : col_addr[7:0] + 8'd1};
				end
			end else begin
				row_addr = regs.row_reverse ? row_addr - 9'd1 : row_addr + 9'd1;
			end
		end else begin
			if (col_addr == regs.x_end) begin
				if (row_addr == regs.y_end && regs.y_start <= regs.y_end) begin
					exhausted = 1'b1;
				end else begin
					col_addr = regs.x_start;
					row_addr = regs.row_reverse ? row_addr - 9'd1 : row_addr + 9'd1;
				end
			end else if (col_addr < 9'd256) begin
				col_addr = {1'b0, regs.col_reverse ? col_addr[7:0] - 8'd1 : col_addr[7:0] + 8'd1};
			end
			// column parked at 256 or above: address frozen until the next load
		end
	endtask

	task automatic finish_pixel(input logic [7:0] r8, input logic [7:0] g8, input logic [7:0] b8);
		if (!exhausted && row_addr < STORE_ROWS && col_addr < STORE_COLS)
			expected_pixels.push_back('{row: row_addr, col: col_addr[7:0], red: r8, green: g8,
				blue: b8});
		walk_window();
	endtask

	// 4-bit channels go through the 16 bpp widening
	task automatic finish_pixel12();
		finish_pixel(widen5({held_third[3:0], 1'b0}), widen6({held_second[3:0], 2'b00}),
			widen5({held_first[3:0], 1'b0}));
	endtask

	task automatic take_byte(input func_t f, input logic [7:0] b);
		logic [1:0] ph;
		case (f)
			FUNC_START: begin
				row_addr   = regs.swap_xy ? regs.x_start : regs.y_start;
				col_addr   = regs.swap_xy ? regs.y_start : regs.x_start;
				exhausted  = 1'b0;
				writing    = 1'b1;
				byte_phase = 2'd0;
			end
			FUNC_CONT: begin
				writing    = 1'b1;
				byte_phase = 2'd0;
			end
			FUNC_OTHER: begin
				writing    = 1'b0;
				byte_phase = 2'd0;
			end
			default: begin
				if (writing) begin
					ph         = byte_phase;
					byte_phase = ph + 2'd1;
					if (regs.pixel_format == FMT_16BPP) begin
						if (ph == 2'd0) begin
							held_first  = {1'b0, b[7:3]};
							held_second = {b[2:0], 3'b000};
						end else if (ph == 2'd1) begin
							held_second = held_second | {3'b000, b[7:5]};
							held_third  = {1'b0, b[4:0]};
							byte_phase  = 2'd0;
							finish_pixel(widen5(held_third[4:0]), widen6(held_second),
								widen5(held_first[4:0]));
						end
					end else if (regs.pixel_format == FMT_12BPP) begin
						if (ph == 2'd0) begin
							held_first  = {2'b00, b[7:4]};
							held_second = {2'b00, b[3:0]};
						end else if (ph == 2'd1) begin
							held_third = {2'b00, b[7:4]};
							finish_pixel12();
							held_first = {2'b00, b[3:0]};
						end else if (ph == 2'd2) begin
							held_second = {2'b00, b[7:4]};
							held_third  = {2'b00, b[3:0]};
							byte_phase  = 2'd0;
							finish_pixel12();
						end
					end else begin
						if (ph == 2'd0) begin
							held_first = b[7:2];
						end else if (ph == 2'd1) begin
							held_second = b[7:2];
						end else if (ph == 2'd2) begin
							held_third = b[7:2];
							byte_phase = 2'd0;
							finish_pixel(widen6(held_third), widen6(held_second), widen6(held_first));
						end
					end
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_total++;
			$display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			regs          = CFG_AT_RESET;
			writing       = 1'b0;
			exhausted     = 1'b0;
			byte_phase    = 2'd0;
			held_first    = '0;
			held_second   = '0;
			held_third    = '0;
			row_addr      = '0;
			col_addr      = '0;
			fail_total    = 0;
			checked_total = 0;
			expected_pixels.delete();
			fails          <= 0;
			pending        <= 0;
			pixels_checked <= 0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					fail_total++;
					$display("%0t: unexpected pixel, expected none, got row %0d col %0d rgb %02h %02h %02h",
						$time, pix_ch.row, pix_ch.col, pix_ch.red, pix_ch.green, pix_ch.blue);
				end else begin
					want = expected_pixels.pop_front();
					check_field("row", want.row, pix_ch.row);
					check_field("col", want.col, pix_ch.col);
					check_field("red", want.red, pix_ch.red);
					check_field("green", want.green, pix_ch.green);
					check_field("blue", want.blue, pix_ch.blue);
					checked_total++;
				end
			end
			if (byte_ch.valid && byte_ch.ready)
				take_byte(func_t'(byte_ch.func), byte_ch.data_byte);
			if (cfg_we) begin
				case (cfg_index)
					REG_X_START:      regs.x_start      = cfg_data;
					REG_X_END:        regs.x_end        = cfg_data;
					REG_Y_START:      regs.y_start      = cfg_data;
					REG_Y_END:        regs.y_end        = cfg_data;
					REG_SWAP_XY:      regs.swap_xy      = cfg_data[0];
					REG_COL_REVERSE:  regs.col_reverse  = cfg_data[0];
					REG_ROW_REVERSE:  regs.row_reverse  = cfg_data[0];
					REG_PIXEL_FORMAT: regs.pixel_format = cfg_data[2:0];
					default: ;
				endcase
			end
			fails          <= fail_total;
			pending        <= expected_pixels.size();
			pixels_checked <= checked_total;
		end
	end

endmodule

FILE: tb/tb_lcd_memory_write_pixel_engine_top.sv
// Top of the pixel engine testbench: clock, reset, byte stimulus, config writes and verdict.
// Depends on lcdmw_pkg, lcdmw_if, lcdmw_pixel_checker and the engine RTL.
module tb_lcd_memory_write_pixel_engine_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lcdmw_pkg::*;

	localparam int QUIET_LIMIT  = 5000;
	localparam int SETTLE       = 4;
	localparam int WINDOW_RUNS  = 12;
	localparam int ITEMS_PER_RUN = 84;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count, pending_pixels, checked_count;
	int          in_idle_pct  = 0;
	int          out_idle_pct = 0;
	int          items_sent   = 0;
	int          quiet_cycles = 0;
	cfg_t        cur_cfg;

	lcdmw_in_if  pix_in();
	lcdmw_out_if pix_out();

	lcd_memory_write_pixel_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcdmw_pixel_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_ch        (pix_in),
		.pix_ch         (pix_out),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fails          (fail_count),
		.pending        (pending_pixels),
		.pixels_checked (checked_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pixel sink with random back-pressure
	initial begin
		pix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			pix_out.ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d pixels outstanding", QUIET_LIMIT,
				pending_pixels);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input func_t f, input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid     <= 1'b1;
		pix_in.func      <= f;
		pix_in.data_byte <= b;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// stop sending, let every predicted pixel come out, then let the pipeline settle
	task automatic drain();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		put_reg(REG_X_START, c.x_start);
		put_reg(REG_X_END, c.x_end);
		put_reg(REG_Y_START, c.y_start);
		put_reg(REG_Y_END, c.y_end);
		// junk in the unused upper bits of the narrow registers
		put_reg(REG_SWAP_XY, {8'($urandom_range(255)), c.swap_xy});
		put_reg(REG_COL_REVERSE, {8'($urandom_range(255)), c.col_reverse});
		put_reg(REG_ROW_REVERSE, {8'($urandom_range(255)), c.row_reverse});
		put_reg(REG_PIXEL_FORMAT, {6'($urandom_range(63)), c.pixel_format});
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic int span_end(input int s, input int w, input logic rev, input int hi);
		if (rev)
			return (s > w) ? s - w : 0;
		return (s + w < hi) ? s + w : hi;
	endfunction

	function automatic cfg_t pick_window_cfg(input int run);
		cfg_t c;
		int   xmax, ymax, s;
		if (run == 0)
			return '{x_start: 9'h1FF, x_end: 9'h1FF, y_start: 9'h1FF, y_end: 9'h1FF, swap_xy: 1'b1,
				col_reverse: 1'b1, row_reverse: 1'b1, pixel_format: 3'd7};
		if (run == 1)
			return '0;
		c.swap_xy     = 1'($urandom_range(1));
		c.col_reverse = 1'($urandom_range(1));
		c.row_reverse = 1'($urandom_range(1));
		case ($urandom_range(3))
			0:       c.pixel_format = FMT_12BPP;
			1:       c.pixel_format = FMT_16BPP;
			default: c.pixel_format = 3'($urandom_range(7));
		endcase
		xmax = c.swap_xy ? STORE_ROWS - 1 : STORE_COLS - 1;
		ymax = c.swap_xy ? STORE_COLS - 1 : STORE_ROWS - 1;
		if ($urandom_range(5) == 0) begin
			c.x_start = 9'($urandom_range(511));
			c.x_end   = 9'($urandom_range(511));
		end else begin
			s         = $urandom_range(xmax);
			c.x_start = 9'(s);
			c.x_end   = 9'(span_end(s, ($urandom_range(3) == 0) ? $urandom_range(xmax) : $urandom_range(7),
				c.swap_xy ? c.row_reverse : c.col_reverse, xmax));
		end
		if ($urandom_range(5) == 0) begin
			c.y_start = 9'($urandom_range(511));
			c.y_end   = 9'($urandom_range(511));
		end else begin
			s         = $urandom_range(ymax);
			c.y_start = 9'(s);
			c.y_end   = 9'(span_end(s, ($urandom_range(3) == 0) ? $urandom_range(ymax) : $urandom_range(7),
				c.swap_xy ? c.col_reverse : c.row_reverse, ymax));
		end
		return c;
	endfunction

	// mostly start/continue followed by whole pixels, with some stray items mixed in
	task automatic run_traffic(input int n);
		int done_items, nbytes;
		done_items = 0;
		while (done_items < n) begin
			if ($urandom_range(6) == 0) begin
				send_item(func_t'($urandom_range(3)), 8'($urandom_range(255)));
				done_items++;
			end else begin
				send_item(($urandom_range(4) == 0) ? FUNC_CONT : FUNC_START, 8'($urandom_range(255)));
				nbytes = $urandom_range(10, 1) * ((cur_cfg.pixel_format == FMT_16BPP) ? 2 : 3);
				repeat (nbytes) send_item(FUNC_DATA, 8'($urandom_range(255)));
				done_items += nbytes + 1;
				if ($urandom_range(3) == 0) begin
					send_item(FUNC_OTHER, 8'($urandom_range(255)));
					done_items++;
				end
			end
		end
	endtask

	task automatic directed_items();
		// reset window, 18 bpp
		send_item(FUNC_DATA, 8'hFF);   // outside pixel mode, dropped
		send_item(FUNC_START, 8'h00);
		send_item(FUNC_DATA, 8'h00);
		send_item(FUNC_DATA, 8'hFF);
		send_item(FUNC_DATA, 8'hA5);
		send_item(FUNC_OTHER, 8'hFF);
		send_item(FUNC_DATA, 8'h11);
		send_item(FUNC_CONT, 8'h55);
		send_item(FUNC_DATA, 8'hFF);
		send_item(FUNC_DATA, 8'h80);
		send_item(FUNC_DATA, 8'h7F);
		drain();

		// two-pixel window at 16 bpp runs dry, then a restart brings it back
		write_cfg('{x_start: 9'd0, x_end: 9'd1, y_start: 9'd0, y_end: 9'd0, swap_xy: 1'b0,
			col_reverse: 1'b0, row_reverse: 1'b0, pixel_format: FMT_16BPP});
		send_item(FUNC_START, 8'h00);
		send_item(FUNC_DATA, 8'hFF);
		send_item(FUNC_DATA, 8'hFF);
		send_item(FUNC_DATA, 8'h00);
		send_item(FUNC_DATA, 8'h00);
		send_item(FUNC_DATA, 8'h12);
		send_item(FUNC_DATA, 8'h34);
		send_item(FUNC_START, 8'h00);
		send_item(FUNC_DATA, 8'hF8);
		send_item(FUNC_DATA, 8'h1F);
		drain();

		// swapped 12 bpp walk down a column, then a format switch mid-pixel
		write_cfg('{x_start: 9'd5, x_end: 9'd7, y_start: 9'd10, y_end: 9'd10, swap_xy: 1'b1,
			col_reverse: 1'b0, row_reverse: 1'b0, pixel_format: FMT_12BPP});
		send_item(FUNC_START, 8'h00);
		send_item(FUNC_DATA, 8'hF0);
		send_item(FUNC_DATA, 8'h0F);
		send_item(FUNC_DATA, 8'hA5);
		send_item(FUNC_DATA, 8'h77);
		send_item(FUNC_DATA, 8'h88);
		drain();
		put_reg(REG_PIXEL_FORMAT, {6'd0, FMT_16BPP});
		cfg_we <= 1'b0;
		cur_cfg.pixel_format = FMT_16BPP;
		send_item(FUNC_DATA, 8'h99);   // phase 2 means nothing at 16 bpp
		send_item(FUNC_DATA, 8'hAA);
		send_item(FUNC_DATA, 8'hBB);
		drain();
	endtask

	initial begin
		pix_in.valid     <= 1'b0;
		pix_in.func      <= FUNC_OTHER;
		pix_in.data_byte <= '0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_X_START;
		cfg_data         <= '0;
		cur_cfg = '{x_start: 9'd0, x_end: 9'd239, y_start: 9'd0, y_end: 9'd319, swap_xy: 1'b0,
			col_reverse: 1'b1, row_reverse: 1'b0, pixel_format: 3'd6};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();

		for (int run = 0; run < WINDOW_RUNS; run++) begin
			case (run / 4)
				0: begin in_idle_pct = 25; out_idle_pct = 56; end
				1: begin in_idle_pct = 56; out_idle_pct = 25; end
				default: begin in_idle_pct = 0; out_idle_pct = 0; end
			endcase
			drain();
			write_cfg(pick_window_cfg(run));
			run_traffic(ITEMS_PER_RUN);
		end
		drain();

		$display("Sent %0d command/data transfers across %0d window settings", items_sent,
			WINDOW_RUNS + 3);
		$display("Checked %0d pixels in 12, 16 and 18 bpp with swap, reversal and window exhaustion",
			checked_count);
		if (fail_count == 0 && pending_pixels == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
